@@ src/smpq_pkg.sv @@
// Shared types and constants for the sorted min-priority queue.
// No dependencies; compiled first.
package smpq_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;   // a transaction is taken this cycle
        logic enq;    // insert the value
        logic deq;    // remove the head entry
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
    } t_flags;

endpackage

@@ src/smpq_if.sv @@
// Valid/ready channel interfaces for the queue's request and response sides.
// Depends on smpq_pkg.
interface smpq_in_if import smpq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    t_opcode                   opcode;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface smpq_out_if import smpq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] out_value;
    t_status                   status;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;

    modport source (output valid, output out_value, output status, output entry_count,
                    output is_empty, input ready);
    modport sink   (input valid, input out_value, input status, input entry_count,
                    input is_empty, output ready);
endinterface

@@ src/smpq_ctrl.sv @@
// Handshake controller: decides the operation and holds the response status.
// Depends on smpq_pkg.
module smpq_ctrl import smpq_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_opcode i_opcode,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_flags  i_flags,
    output t_cmd    o_cmd,
    output t_status o_status
);

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } t_state;

    t_state  r_state;
    t_status r_status;
    t_state  n_state;
    t_status n_status;
    logic    w_accept;

    assign o_in_ready  = (r_state == S_IDLE) || i_out_ready;
    assign o_out_valid = (r_state == S_HOLD);
    assign o_status    = r_status;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.load = w_accept;
        o_cmd.enq  = w_accept && (i_opcode == OP_ENQ) && !i_flags.full;
        o_cmd.deq  = w_accept && (i_opcode == OP_DEQ) && !i_flags.empty;
        n_state    = r_state;
        n_status   = r_status;
        if (w_accept) begin
            n_state = S_HOLD;
            if (i_opcode == OP_ENQ) begin
                n_status = i_flags.full ? ST_OVERFLOW : ST_OK;
            end else begin
                n_status = i_flags.empty ? ST_UNDERFLOW : ST_OK;
            end
        end else if (i_out_ready) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

@@ src/smpq_dp.sv @@
// Datapath: a row of compare-and-shift cells, the entry count and the result value.
// Depends on smpq_pkg.
module smpq_dp import smpq_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic signed [VALUE_W-1:0] i_value,
    output t_flags                    o_flags,
    output logic signed [VALUE_W-1:0] o_out_value,
    output logic [COUNT_W-1:0]        o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    logic signed [DATA_WIDTH-1:0] r_cell [CAPACITY];
    logic signed [DATA_WIDTH-1:0] n_cell [CAPACITY];
    logic [CAPACITY-1:0]          w_le;      // cell holds an entry <= new value
    logic [CW-1:0]                r_count;
    logic signed [VALUE_W-1:0]    r_out_value;
    logic signed [EW-1:0]         w_in_ext;
    logic signed [DATA_WIDTH-1:0] w_key;
    logic signed [EW-1:0]         w_head_ext;

    assign w_in_ext   = EW'(i_value);
    assign w_key      = w_in_ext[DATA_WIDTH-1:0];
    assign w_head_ext = EW'(r_cell[0]);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_le[g] = (CW'(g) < r_count) && (r_cell[g] <= w_key);

        always_comb begin
            n_cell[g] = r_cell[g];
            if (i_cmd.enq) begin
                if (w_le[g]) begin
                    n_cell[g] = r_cell[g];
                end else if (g == 0) begin
                    n_cell[g] = w_key;
                end else if (w_le[(g > 0) ? g - 1 : 0]) begin
                    n_cell[g] = w_key;
                end else begin
                    n_cell[g] = r_cell[(g > 0) ? g - 1 : 0];
                end
            end else if (i_cmd.deq) begin
                if (g < CAPACITY - 1) begin
                    n_cell[g] = r_cell[(g < CAPACITY - 1) ? g + 1 : g];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_cell[g] <= n_cell[g];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.enq) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.deq) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_value <= i_cmd.deq ? w_head_ext[VALUE_W-1:0] : '0;
        end
    end

    assign o_flags.empty  = (r_count == '0);
    assign o_flags.full   = (r_count == CW'(CAPACITY));
    assign o_out_value    = r_out_value;
    assign o_entry_count  = COUNT_W'(r_count);

endmodule

@@ src/sorted_min_priority_queue.sv @@
// Top level of the sorted min-priority queue.
// Depends on smpq_pkg, smpq_if, smpq_ctrl and smpq_dp.
//
// Usage:
//   i_in  (sink)   : one transaction per request; opcode OP_ENQ inserts value,
//                    OP_DEQ removes the smallest entry. Equal values leave in
//                    arrival order.
//   o_out (source) : exactly one transaction per request, carrying the removed
//                    value (zero unless a dequeue succeeded), a status code
//                    (ok, underflow on empty dequeue, overflow on full enqueue),
//                    the entry count after the request and an empty flag.
// Latency: the response is valid the cycle after the request is taken.
// Throughput: one request per cycle while o_out.ready is high. Every cell of the sorted row compares
//   against the new value in parallel and shifts by at most one place, so an
//   insert or a remove updates the whole row at once whatever the fill level.
// Stall: the response register holds its transaction while o_out.ready is low;
//   a new request is taken only when that register is empty or being drained
//   in the same cycle, so i_in.ready follows o_out.ready combinationally.
// Reset: synchronous, active low; the queue comes up empty with no response
//   pending. Cell contents are not cleared; only slots below the count are read.
module sorted_min_priority_queue import smpq_pkg::*; #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    smpq_in_if.sink    i_in,
    smpq_out_if.source o_out
);

    t_cmd   w_cmd;
    t_flags w_flags;

    // handshake and operation decode
    smpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_opcode    (i_in.opcode),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_flags     (w_flags),
        .o_cmd       (w_cmd),
        .o_status    (o_out.status)
    );

    // sorted storage and result value
    smpq_dp #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_value       (i_in.value),
        .o_flags       (w_flags),
        .o_out_value   (o_out.out_value),
        .o_entry_count (o_out.entry_count)
    );

    // count only changes with a new transaction, so it matches the held response
    assign o_out.is_empty = (o_out.entry_count == '0);

endmodule

@@ tb/sv/tb_sorted_min_priority_queue.sv @@
// Self-checking testbench for sorted_min_priority_queue: directed and random
// enqueue/dequeue traffic checked against a behavioral sorted-list predictor.
// Depends on smpq_pkg, smpq_if and the queue RTL.
`timescale 1ns / 1ps

module tb_sorted_min_priority_queue;
    import smpq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int ENTRY_W     = 32;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int RAND_ROUNDS = 37;
    localparam int ROUND_ITEMS = 50;

    typedef struct {
        logic signed [VALUE_W-1:0] out_value;
        t_status                   status;
        logic [COUNT_W-1:0]        entry_count;
        logic                      is_empty;
    } t_queue_response;

    logic i_clk = 1'b0;
    logic i_rst_n;

    smpq_in_if  in_ch ();
    smpq_out_if out_ch ();

    sorted_min_priority_queue #(
        .CAPACITY   (QUEUE_DEPTH),
        .DATA_WIDTH (ENTRY_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Predictor state: entries kept sorted ascending, head at index 0.
    logic signed [VALUE_W-1:0] model_entries[$];
    t_queue_response           pending_responses[$];
    int                        mismatches  = 0;
    int                        cycle_count = 0;
    int                        idle_pct    = 8;

    always #6 i_clk = ~i_clk;

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d responses outstanding", $time,
                     pending_responses.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Response side back-pressure
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Next state of the sorted list and the response it gives.
    function automatic t_queue_response apply_queue_request(t_opcode op,
                                                            logic signed [VALUE_W-1:0] v);
        t_queue_response resp;
        int              pos;
        resp.out_value = '0;
        resp.status    = ST_OK;
        if (op == OP_ENQ) begin
            if (model_entries.size() >= QUEUE_DEPTH) begin
                resp.status = ST_OVERFLOW;
            end else begin
                // after every entry <= v, so ties keep arrival order
                pos = 0;
                while (pos < model_entries.size() && model_entries[pos] <= v) pos++;
                model_entries.insert(pos, v);
            end
        end else begin
            if (model_entries.size() == 0) begin
                resp.status = ST_UNDERFLOW;
            end else begin
                resp.out_value = model_entries.pop_front();
            end
        end
        resp.entry_count = COUNT_W'(model_entries.size());
        resp.is_empty    = (model_entries.size() == 0);
        return resp;
    endfunction

    // Drive one request; valid stays high on return so back-to-back requests
    // need no low cycle. Prediction happens at the accepting edge.
    task automatic send_request(t_opcode op, logic signed [VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.value  <= v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pending_responses.push_back(apply_queue_request(op, v));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_responses.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] rand_entry_value();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6, 7:       v = int'($urandom_range(0, 8)) - 4;  // many ties
            8:             v = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default:       v = $urandom_range(0, 1) ? -32'sd1 : 32'sd0;
        endcase
        return v;
    endfunction

    // Scoreboard: each response against the oldest prediction
    always @(posedge i_clk) begin
        t_queue_response want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_responses.size() == 0) begin
                $display("%0t: response with nothing expected: value %0d status %0d count %0d",
                         $time, out_ch.out_value, out_ch.status, out_ch.entry_count);
                mismatches++;
            end else begin
                want = pending_responses.pop_front();
                if (out_ch.out_value !== want.out_value) begin
                    $display("%0t: out_value expected %0d actual %0d", $time,
                             want.out_value, out_ch.out_value);
                    mismatches++;
                end
                if (out_ch.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, out_ch.status);
                    mismatches++;
                end
                if (out_ch.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d", $time,
                             want.entry_count, out_ch.entry_count);
                    mismatches++;
                end
                if (out_ch.is_empty !== want.is_empty) begin
                    $display("%0t: is_empty expected %0b actual %0b", $time,
                             want.is_empty, out_ch.is_empty);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_empty_dequeue();
        send_request(OP_DEQ, $urandom);
    endtask

    // Extremes, ties and alternating bit patterns, exactly filling the queue.
    task automatic test_fill_to_capacity();
        logic signed [VALUE_W-1:0] fill_values[QUEUE_DEPTH] = '{
            32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1,
            32'sd1, 32'sh8000_0001, 32'sh7fff_fffe, 32'sd5,
            32'sd5, -32'sd5, 32'sh5555_5555, 32'shaaaa_aaaa,
            32'sd0, 32'sd7, -32'sd7, 32'sd100
        };
        foreach (fill_values[k]) send_request(OP_ENQ, fill_values[k]);
    endtask

    task automatic test_full_enqueue();
        send_request(OP_ENQ, 32'sh7fff_ffff);
        send_request(OP_ENQ, 32'sh8000_0000);
    endtask

    task automatic test_head_removal();
        repeat (4) send_request(OP_DEQ, $urandom);
        wait_drained();
    endtask

    // Rounds with a random enqueue bias walk the fill level between empty and
    // full; a block of rounds runs with no idling on either side.
    task automatic test_random_traffic();
        int enq_pct;
        for (int r = 0; r < RAND_ROUNDS; r++) begin
            idle_pct = (r >= 10 && r < 16) ? 0 : 8;
            case ($urandom_range(0, 2))
                0:       enq_pct = 15;
                1:       enq_pct = 50;
                default: enq_pct = 85;
            endcase
            for (int n = 0; n < ROUND_ITEMS; n++) begin
                if ($urandom_range(0, 99) < enq_pct) send_request(OP_ENQ, rand_entry_value());
                else                                 send_request(OP_DEQ, $urandom);
            end
            if (r % 6 == 5) wait_drained();
        end
        idle_pct = 8;
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.opcode <= OP_ENQ;
        in_ch.value  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_dequeue();
        test_fill_to_capacity();
        test_full_enqueue();
        test_head_removal();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/smpq_pkg.sv
src/smpq_if.sv
src/smpq_ctrl.sv
src/smpq_dp.sv
src/sorted_min_priority_queue.sv
tb/sv/tb_sorted_min_priority_queue.sv
